// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl of the ordered list search and delete unit
// expects a clock named clk and an active-low reset named rst_n in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define OLSD_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("olsd assertion failed");

// condition must never be true outside reset
`define OLSD_NEVER(label, cond) \
  `OLSD_ASSERT(label, !(cond))

`endif

// ===== rtl/olsd_pkg.sv =====
// shared constants, types and helpers of the ordered list search and delete unit
// no dependencies
package olsd_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int VAL_W = 32;
  localparam int ACT_W = 2;
  localparam int OCNT_W = 7;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_t;

  function automatic logic [OCNT_W-1:0] count_to_port(input logic [CNT_W-1:0] c);
    logic [CNT_W+OCNT_W-1:0] ext;
    ext = (CNT_W + OCNT_W)'(c);
    return ext[OCNT_W-1:0];
  endfunction

endpackage

// ===== rtl/olsd_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module olsd_ram #(
  parameter int WORDS = 64,
  parameter int DATA_W = 32,
  parameter int ADDR_W = (WORDS > 2) ? $clog2(WORDS) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [WORDS];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/ordered_list_search_delete_unit.sv =====
// top level of the ordered list search and delete unit
// depends on olsd_pkg, olsd_ram and assert_macros.svh
//
// Keeps up to DEPTH signed 32-bit values in arrival order in one synchronous
// ram, one entry read per cycle. One item is worked on at a time; the next
// item is taken as soon as the unit is idle, even while the last result still
// waits on the output register. Append and the unused action code go straight
// to the done state; a search scans from the head up to the first match or the
// current count; a remove also scans up to the first match, then does one read
// and one write per cycle to close the gap behind it. The single ram read port
// steps one entry per cycle. No clearing pass is needed after reset: only
// entries below the count are ever read.
`include "assert_macros.svh"

module ordered_list_search_delete_unit (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic [olsd_pkg::ACT_W-1:0]                in_action,
  input  logic signed [olsd_pkg::VAL_W-1:0]         in_item_value,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic                                      out_hit,
  output logic                                      out_dropped,
  output logic [olsd_pkg::OCNT_W-1:0]               out_entry_count
);

  import olsd_pkg::*;

  state_t state_r, state_nxt;
  logic [ACT_W-1:0] act_r, act_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic             pend_r, pend_nxt;
  logic             res_hit_r, res_hit_nxt;
  logic             res_drop_r, res_drop_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_hit_r, out_hit_nxt;
  logic             out_dropped_r, out_dropped_nxt;
  logic [OCNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_wa;
  logic [VAL_W-1:0] ram_wd;
  logic             ram_re;
  logic [IDX_W-1:0] ram_ra;
  logic [VAL_W-1:0] ram_rd;

  logic in_xfer;
  logic issue;
  logic match;

  olsd_ram #(
    .WORDS  (DEPTH),
    .DATA_W (VAL_W),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .rd_en   (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign issue    = (idx_r < cnt_r);
  assign match    = pend_r && (ram_rd == val_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r         <= act_nxt;
    val_r         <= val_nxt;
    idx_r         <= idx_nxt;
    pos_r         <= pos_nxt;
    res_hit_r     <= res_hit_nxt;
    res_drop_r    <= res_drop_nxt;
    out_hit_r     <= out_hit_nxt;
    out_dropped_r <= out_dropped_nxt;
    out_cnt_r     <= out_cnt_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    act_nxt         = act_r;
    val_nxt         = val_r;
    cnt_nxt         = cnt_r;
    idx_nxt         = idx_r;
    pos_nxt         = pos_r;
    pend_nxt        = 1'b0;
    res_hit_nxt     = res_hit_r;
    res_drop_nxt    = res_drop_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_hit_nxt     = out_hit_r;
    out_dropped_nxt = out_dropped_r;
    out_cnt_nxt     = out_cnt_r;
    ram_we          = 1'b0;
    ram_wa          = cnt_r[IDX_W-1:0];
    ram_wd          = in_item_value;
    ram_re          = 1'b0;
    ram_ra          = idx_r[IDX_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          act_nxt      = in_action;
          val_nxt      = in_item_value;
          idx_nxt      = '0;
          res_hit_nxt  = 1'b0;
          res_drop_nxt = 1'b0;
          priority case (in_action)
            ACT_APPEND: begin
              if (cnt_r < DEPTH_CNT) begin
                ram_we  = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end else begin
                res_drop_nxt = 1'b1;
              end
              state_nxt = ST_DONE;
            end
            ACT_SEARCH, ACT_REMOVE: begin
              state_nxt = ST_SCAN;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (match) begin
          res_hit_nxt = 1'b1;
          if (act_r == ACT_REMOVE) begin
            idx_nxt   = pos_r + 1'b1;
            state_nxt = ST_SHIFT;
          end else begin
            state_nxt = ST_DONE;
          end
        end else if (issue) begin
          ram_re   = 1'b1;
          pend_nxt = 1'b1;
          pos_nxt  = idx_r;
          idx_nxt  = idx_r + 1'b1;
        end else if (!pend_r) begin
          state_nxt = ST_DONE;
        end
      end

      ST_SHIFT: begin
        // pos_r is the write pointer, idx_r the read pointer ahead of it
        if (pend_r) begin
          ram_we  = 1'b1;
          ram_wa  = pos_r[IDX_W-1:0];
          ram_wd  = ram_rd;
          pos_nxt = pos_r + 1'b1;
        end
        if (issue) begin
          ram_re   = 1'b1;
          pend_nxt = 1'b1;
          idx_nxt  = idx_r + 1'b1;
        end else if (!pend_r) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_hit_nxt     = res_hit_r;
          out_dropped_nxt = res_drop_r;
          out_cnt_nxt     = count_to_port(cnt_r);
          state_nxt       = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_dropped     = out_dropped_r;
  assign out_entry_count = out_cnt_r;

  // assertions
  `OLSD_NEVER(a_cnt_bound, cnt_r > DEPTH_CNT)
  `OLSD_ASSERT(a_wr_in_range, ram_we |-> (CNT_W'(ram_wa) <= cnt_r))
  `OLSD_ASSERT(a_shift_on_remove, (state_r == ST_SHIFT) |-> (act_r == ACT_REMOVE))
  `OLSD_NEVER(a_hit_drop_excl, out_valid_r && out_hit_r && out_dropped_r)

endmodule

// ===== verif/tb_ordered_list_search_delete_unit.sv =====
// testbench for ordered_list_search_delete_unit: random and directed append, search and
// remove transfers checked against an in-bench model of the ordered list
// depends on olsd_pkg and the rtl of ordered_list_search_delete_unit
module tb_ordered_list_search_delete_unit;
  import olsd_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int N_SEGMENTS = 10;
  localparam int SEG_ITEMS = 50;
  localparam int TAIL_CYCLES = 2 * DEPTH + 20;

  localparam int MIX_FILL = 0;
  localparam int MIX_BALANCED = 1;
  localparam int MIX_DRAIN = 2;

  typedef struct {
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] value;
    int                      idle_pct;
    int                      stall_pct;
    bit                      drain_first;
  } list_request_t;

  typedef struct packed {
    logic              hit;
    logic              dropped;
    logic [OCNT_W-1:0] count;
  } list_answer_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [ACT_W-1:0]        in_action = '0;
  logic signed [VAL_W-1:0] in_item_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_hit;
  logic                    out_dropped;
  logic [OCNT_W-1:0]       out_entry_count;

  list_request_t           requests_to_send[$];
  list_answer_t            answers_due[$];
  list_request_t           next_request;
  list_answer_t            oldest_answer;
  logic signed [VAL_W-1:0] list_vals [DEPTH];
  int                      list_len = 0;
  int                      stall_pct = 0;
  int                      errors = 0;
  bit                      in_taken = 1'b0;

  ordered_list_search_delete_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_item_value   (in_item_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_dropped     (out_dropped),
    .out_entry_count (out_entry_count)
  );

  always #1 clk = ~clk;

  // list model: applies one operation and queues the answer it gives
  task automatic apply_list_op(input logic [ACT_W-1:0] act,
                               input logic signed [VAL_W-1:0] v);
    list_answer_t ans;
    int           pos;
    ans = '0;
    pos = -1;
    for (int i = 0; i < list_len; i++) begin
      if (pos < 0 && list_vals[i] == v) pos = i;
    end
    case (act)
      ACT_APPEND: begin
        if (list_len < DEPTH) begin
          list_vals[list_len] = v;
          list_len++;
        end else begin
          ans.dropped = 1'b1;
        end
      end
      ACT_SEARCH: ans.hit = (pos >= 0);
      ACT_REMOVE: begin
        if (pos >= 0) begin
          for (int i = pos; i < list_len - 1; i++) list_vals[i] = list_vals[i + 1];
          list_len--;
          ans.hit = 1'b1;
        end
      end
      default: ;
    endcase
    ans.count = OCNT_W'(list_len);
    answers_due.push_back(ans);
  endtask

  task automatic add_request(input logic [ACT_W-1:0] act, input logic signed [VAL_W-1:0] v,
                             input int idle, input int stall, input bit drain);
    list_request_t r;
    r.action = act;
    r.value = v;
    r.idle_pct = idle;
    r.stall_pct = stall;
    r.drain_first = drain;
    requests_to_send.push_back(r);
  endtask

  // small pool so that searches and removes often match
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(12))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h00000000;
      3: return 32'hffffffff;
      4: return 32'h00000001;
      5: return 32'h55555555;
      6: return 32'haaaaaaaa;
      7: return 32'h00000007;
      8: return -32'sd7;
      9: return 32'h12345678;
      10: return -32'sd100;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ACT_W-1:0] pick_action(input int mix);
    int r;
    r = $urandom_range(99);
    case (mix)
      MIX_FILL:
        return (r < 80) ? ACT_APPEND : (r < 88) ? ACT_SEARCH : (r < 97) ? ACT_REMOVE : ACT_UNUSED;
      MIX_BALANCED:
        return (r < 40) ? ACT_APPEND : (r < 70) ? ACT_SEARCH : (r < 95) ? ACT_REMOVE : ACT_UNUSED;
      default:
        return (r < 15) ? ACT_APPEND : (r < 35) ? ACT_SEARCH : (r < 95) ? ACT_REMOVE : ACT_UNUSED;
    endcase
  endfunction

  // driver: a new transfer is offered only once the previous one was taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (requests_to_send.size() != 0 &&
          $urandom_range(99) >= requests_to_send[0].idle_pct &&
          !(requests_to_send[0].drain_first && answers_due.size() != 0)) begin
        next_request = requests_to_send.pop_front();
        in_valid <= 1'b1;
        in_action <= next_request.action;
        in_item_value <= next_request.value;
        stall_pct <= next_request.stall_pct;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  // monitor: checks results, then feeds accepted transfers to the list model
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          $display("%0t unexpected result: hit %0d dropped %0d count %0d", $time,
                   out_hit, out_dropped, out_entry_count);
          errors++;
        end else begin
          oldest_answer = answers_due.pop_front();
          if (out_hit !== oldest_answer.hit) begin
            $display("%0t hit mismatch: expected %0d actual %0d", $time,
                     oldest_answer.hit, out_hit);
            errors++;
          end
          if (out_dropped !== oldest_answer.dropped) begin
            $display("%0t dropped mismatch: expected %0d actual %0d", $time,
                     oldest_answer.dropped, out_dropped);
            errors++;
          end
          if (out_entry_count !== oldest_answer.count) begin
            $display("%0t entry_count mismatch: expected %0d actual %0d", $time,
                     oldest_answer.count, out_entry_count);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        apply_list_op(in_action, in_item_value);
      end
    end
  end

  initial begin
    int idle;
    int stall;
    int mix;
    // empty store cases
    add_request(ACT_SEARCH, 32'h00000000, 0, 0, 1'b0);
    add_request(ACT_REMOVE, 32'h00000000, 0, 0, 1'b0);
    add_request(ACT_UNUSED, 32'hffffffff, 0, 0, 1'b0);
    // extremes of the value
    add_request(ACT_APPEND, 32'h7fffffff, 0, 0, 1'b0);
    add_request(ACT_APPEND, 32'h80000000, 0, 0, 1'b0);
    add_request(ACT_APPEND, 32'h00000000, 0, 0, 1'b0);
    add_request(ACT_APPEND, 32'hffffffff, 0, 0, 1'b0);
    add_request(ACT_APPEND, 32'h00000001, 0, 0, 1'b0);
    add_request(ACT_SEARCH, 32'h80000000, 0, 0, 1'b0);
    add_request(ACT_SEARCH, 32'h00000005, 0, 0, 1'b0);
    add_request(ACT_SEARCH, 32'h00000001, 0, 0, 1'b0);
    // remove from the middle, then a miss
    add_request(ACT_REMOVE, 32'hffffffff, 0, 0, 1'b0);
    add_request(ACT_REMOVE, 32'h0000002a, 0, 0, 1'b0);
    add_request(ACT_SEARCH, 32'hffffffff, 0, 0, 1'b0);
    // duplicates: only the first equal entry goes
    add_request(ACT_APPEND, 32'h00000000, 0, 0, 1'b0);
    add_request(ACT_REMOVE, 32'h00000000, 0, 0, 1'b0);
    add_request(ACT_SEARCH, 32'h00000000, 0, 0, 1'b0);
    add_request(ACT_UNUSED, 32'h5a5a5a5a, 0, 0, 1'b0);
    // remove at head and tail
    add_request(ACT_REMOVE, 32'h7fffffff, 0, 0, 1'b0);
    add_request(ACT_REMOVE, 32'h00000000, 0, 0, 1'b0);
    add_request(ACT_SEARCH, 32'h7fffffff, 0, 0, 1'b0);

    // fill-heavy, balanced and drain-heavy segments; fill-heavy ones reach a full store and dropped appends
    for (int seg = 0; seg < N_SEGMENTS; seg++) begin
      case (seg % 5)
        0: begin idle = 0; stall = 0; end
        1: begin idle = 65; stall = 0; end
        2: begin idle = 0; stall = 65; end
        3: begin idle = 7; stall = 7; end
        default: begin idle = 0; stall = 0; end
      endcase
      case (seg % 4)
        0, 1: mix = MIX_FILL;
        2: mix = MIX_BALANCED;
        default: mix = MIX_DRAIN;
      endcase
      for (int k = 0; k < SEG_ITEMS; k++) begin
        add_request(pick_action(mix), pick_value(), idle, stall,
                    k == 0 && (seg == 0 || seg == 5));
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (requests_to_send.size() != 0 || in_valid) @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
